/* sv/sxlm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sxlm_pkg;

  // Largest burst of the long register commands
  localparam int unsigned MAX_BYTES   = 8;
  localparam int unsigned HP_W        = 10;
  localparam logic [HP_W-1:0] HP_RESET = 10'd10;

  localparam int unsigned PRE_LEN     = 27;
  localparam logic [3:0] CMD_BL_LOAD  = 4'd13;
  localparam logic [3:0] BYTE_BL_LOAD = 4'd9;
  localparam logic [3:0] RX_BITS      = 4'd9;
  localparam logic [3:0] HDR_FRAMES   = 4'd3;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_READ     = 8'h38;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_PRE     = 13'b0000000000010,
    ST_TX_HI   = 13'b0000000000100,
    ST_TX_LO   = 13'b0000000001000,
    ST_PARK_HI = 13'b0000000010000,
    ST_PARK_LO = 13'b0000000100000,
    ST_ACK_HI  = 13'b0000001000000,
    ST_ACK_LO  = 13'b0000010000000,
    ST_END_HI  = 13'b0000100000000,
    ST_END_LO  = 13'b0001000000000,
    ST_RX_HI   = 13'b0010000000000,
    ST_RX_LO   = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NACK   = 2'd1,
    STAT_PARITY = 2'd2
  } status_e;

  typedef struct packed {
    logic        start_req;
    logic        opcode;
    logic [3:0]  slave_id;
    logic [15:0] reg_addr;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
    logic        data_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_out;
    logic        clock_drive;
    logic        data_out;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [63:0] read_data;
  } res_t;

  // Odd parity over up to 12 bits: 1 when the number of ones is even
  function automatic logic odd_par(input logic [11:0] v);
    return ~^v;
  endfunction

  // Arbitration and start-condition levels: {data enable, data, clock}
  function automatic logic [2:0] pre_level(input logic [4:0] idx);
    logic [2:0] lv;
    lv = 3'd0;
    case (idx)
      5'd0, 5'd1:                         lv = 3'd4;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6:       lv = 3'd6;
      5'd7:                               lv = 3'd7;
      5'd8:                               lv = 3'd6;
      5'd9:                               lv = 3'd5;
      5'd10:                              lv = 3'd4;
      5'd11:                              lv = 3'd7;
      5'd12:                              lv = 3'd6;
      5'd13, 5'd15, 5'd17, 5'd19, 5'd21:  lv = 3'd1;
      5'd14, 5'd16, 5'd18, 5'd20, 5'd22:  lv = 3'd0;
      5'd23:                              lv = 3'd7;
      5'd24, 5'd25:                       lv = 3'd6;
      5'd26:                              lv = 3'd4;
      default:                            lv = 3'd0;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

/* sv/sxlm_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module sxlm_in_reg (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [sxlm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire                               s_axis_tuser,
  input  wire                               adv_i,
  output logic                              vld_o,
  output sxlm_pkg::in_item_t                item_o
);
  import sxlm_pkg::*;

  logic     vld_q, vld_d;
  in_item_t item_q;
  logic     take;

  assign s_axis_tready = !vld_q || adv_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // unpack the transaction: opcode rides on tuser
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.start_req  <= s_axis_tdata[0];
      item_q.opcode     <= s_axis_tuser;
      item_q.slave_id   <= s_axis_tdata[4:1];
      item_q.reg_addr   <= s_axis_tdata[20:5];
      item_q.byte_count <= s_axis_tdata[24:21];
      item_q.write_data <= s_axis_tdata[88:25];
      item_q.data_in    <= s_axis_tdata[89];
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

/* sv/sxlm_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module sxlm_seq (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [sxlm_pkg::HP_W-1:0]  cfg_wdata_i,
  input  wire                       step_i,
  input  sxlm_pkg::in_item_t        item_i,
  output sxlm_pkg::res_t            res_o
);
  import sxlm_pkg::*;

  typedef struct packed {
    logic [12:0] fs;
    logic [3:0]  bl;
  } frame_t;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  slave_id;
    logic [15:0] reg_addr;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
  } req_t;

  logic [HP_W-1:0] hp_q;
  state_e          state_q, state_d, cur;
  logic [4:0]      pre_idx_q, pre_idx_d;
  logic [9:0]      tick_q, tick_d;
  logic [12:0]     fs_q, fs_d;
  logic [3:0]      bl_q, bl_d;
  logic [3:0]      bi_q, bi_d;
  logic [63:0]     acc_q, acc_d;
  status_e         stat_q, stat_d;
  req_t            req_q, req_d;

  function automatic frame_t tx_frame(input logic [3:0] f, input req_t r);
    frame_t     fr;
    logic [7:0] v;
    logic [2:0] b;
    logic [11:0] cmd;
    b   = 3'(f - HDR_FRAMES);
    cmd = {r.slave_id, (r.opcode ? CMD_READ : CMD_WRITE) | {4'd0, r.byte_count - 4'd1}};
    case (f)
      4'd0:    v = 8'd0;
      4'd1:    v = r.reg_addr[15:8];
      4'd2:    v = r.reg_addr[7:0];
      default: v = r.write_data[8*b +: 8];
    endcase
    if (f == 4'd0) begin
      fr.fs = {cmd, odd_par(cmd)};
      fr.bl = CMD_BL_LOAD;
    end else begin
      fr.fs = {4'd0, v, odd_par({4'd0, v})};
      fr.bl = BYTE_BL_LOAD;
    end
    return fr;
  endfunction

  logic [HP_W-1:0] hp_eff;
  logic [HP_W:0]   tick_sum;
  logic [2:0]      lv;
  logic [3:0]      frames;
  logic [7:0]      rx_byte;
  logic            cnt_ok;
  frame_t          fr;

  assign hp_eff = (hp_q == '0) ? HP_W'(1) : hp_q;
  assign cnt_ok = (item_i.byte_count != 4'd0) && (item_i.byte_count <= 4'(MAX_BYTES));

  always_comb begin
    state_d   = state_q;
    pre_idx_d = pre_idx_q;
    tick_d    = tick_q;
    fs_d      = fs_q;
    bl_d      = bl_q;
    bi_d      = bi_q;
    acc_d     = acc_q;
    stat_d    = stat_q;
    req_d     = req_q;
    lv        = 3'd0;
    tick_sum  = '0;
    frames    = '0;
    rx_byte   = '0;
    fr        = '0;
    res_o     = '0;

    if (state_q == ST_IDLE && item_i.start_req && cnt_ok) begin
      req_d.opcode     = item_i.opcode;
      req_d.slave_id   = item_i.slave_id;
      req_d.reg_addr   = item_i.reg_addr;
      req_d.byte_count = item_i.byte_count;
      req_d.write_data = item_i.write_data;
      acc_d     = '0;
      stat_d    = STAT_OK;
      tick_d    = '0;
      pre_idx_d = '0;
      state_d   = ST_PRE;
    end

    cur = state_d;
    if (cur == ST_DONE) begin
      res_o.done_res = 1'b1;
      res_o.status   = stat_d;
      state_d        = ST_IDLE;
    end else if (cur != ST_IDLE) begin
      res_o.busy_res    = 1'b1;
      res_o.clock_drive = 1'b1;
      case (cur)
        ST_PRE:     lv = pre_level(pre_idx_d);
        ST_TX_HI,
        ST_TX_LO:   begin
          lv[2] = 1'b1;
          lv[0] = (cur == ST_TX_HI);
          if (bl_d != 4'd0 && bl_d <= CMD_BL_LOAD) begin
            lv[1] = fs_d[bl_d - 4'd1];
          end
        end
        ST_PARK_HI: lv = 3'd5;
        ST_ACK_HI,
        ST_END_HI,
        ST_RX_HI:   lv = 3'd1;
        default:    lv = 3'd0;
      endcase

      // sample on the first tick of the phase
      if (tick_d == '0) begin
        if (cur == ST_RX_HI) begin
          fs_d = {4'd0, fs_d[7:0], item_i.data_in};
        end else if (cur == ST_ACK_LO) begin
          stat_d = item_i.data_in ? STAT_OK : STAT_NACK;
        end
      end

      tick_sum = {1'b0, tick_d} + 1'b1;
      if (tick_sum >= {1'b0, hp_eff}) begin
        tick_d = '0;
        unique case (cur)
          ST_PRE: begin
            if (pre_idx_d < 5'(PRE_LEN - 1)) begin
              pre_idx_d = pre_idx_d + 5'd1;
            end else begin
              bi_d    = '0;
              fr      = tx_frame(4'd0, req_d);
              fs_d    = fr.fs;
              bl_d    = fr.bl;
              state_d = ST_TX_HI;
            end
          end
          ST_TX_HI:   state_d = ST_TX_LO;
          ST_TX_LO: begin
            if (bl_d != 4'd0) begin
              bl_d = bl_d - 4'd1;
            end
            if (bl_d != 4'd0) begin
              state_d = ST_TX_HI;
            end else begin
              bi_d   = bi_d + 4'd1;
              frames = HDR_FRAMES + (req_d.opcode ? 4'd0 : req_d.byte_count);
              if (bi_d < frames) begin
                fr      = tx_frame(bi_d, req_d);
                fs_d    = fr.fs;
                bl_d    = fr.bl;
                state_d = ST_TX_HI;
              end else begin
                state_d = ST_PARK_HI;
              end
            end
          end
          ST_PARK_HI: state_d = ST_PARK_LO;
          ST_PARK_LO: begin
            if (req_d.opcode) begin
              bi_d    = '0;
              bl_d    = RX_BITS;
              fs_d    = '0;
              state_d = ST_RX_HI;
            end else begin
              state_d = ST_ACK_HI;
            end
          end
          ST_ACK_HI:  state_d = ST_ACK_LO;
          ST_ACK_LO:  state_d = ST_END_HI;
          ST_END_HI:  state_d = ST_END_LO;
          ST_END_LO:  state_d = ST_DONE;
          ST_RX_HI:   state_d = ST_RX_LO;
          ST_RX_LO: begin
            if (bl_d != 4'd0) begin
              bl_d = bl_d - 4'd1;
            end
            if (bl_d != 4'd0) begin
              state_d = ST_RX_HI;
            end else begin
              rx_byte = fs_d[8:1];
              for (int k = 0; k < 8; k++) begin
                if (bi_d[2:0] == 3'(k)) begin
                  acc_d[8*k +: 8] = acc_d[8*k +: 8] | rx_byte;
                end
              end
              // drop out at the first bad byte
              if (fs_d[0] != odd_par({4'd0, rx_byte})) begin
                stat_d  = STAT_PARITY;
                state_d = ST_END_HI;
              end else begin
                bi_d = bi_d + 4'd1;
                if (bi_d < req_d.byte_count) begin
                  bl_d    = RX_BITS;
                  fs_d    = '0;
                  state_d = ST_RX_HI;
                end else begin
                  state_d = ST_END_HI;
                end
              end
            end
          end
          default:    state_d = ST_IDLE;
        endcase
      end else begin
        tick_d = tick_sum[HP_W-1:0];
      end
    end

    res_o.clock_out  = lv[0];
    res_o.data_out   = lv[1];
    res_o.data_drive = lv[2];
    res_o.read_data  = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= HP_RESET;
    end else if (cfg_we_i) begin
      hp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pre_idx_q <= '0;
      tick_q    <= '0;
      acc_q     <= '0;
      stat_q    <= STAT_OK;
    end else if (step_i) begin
      state_q   <= state_d;
      pre_idx_q <= pre_idx_d;
      tick_q    <= tick_d;
      acc_q     <= acc_d;
      stat_q    <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      fs_q  <= fs_d;
      bl_q  <= bl_d;
      bi_q  <= bi_d;
      req_q <= req_d;
    end
  end

`ifndef ASSERT_OFF
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && state_q == ST_DONE) |=> state_q == ST_IDLE)
    else $error("done phase not followed by idle");

  a_tx_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TX_HI || state_q == ST_TX_LO) |-> (bl_q != 4'd0 && bl_q <= CMD_BL_LOAD))
    else $error("transmit phase with no bit left");

  a_rx_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RX_HI || state_q == ST_RX_LO) |-> bi_q < req_q.byte_count)
    else $error("read byte index past requested count");

  a_pre_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRE |-> pre_idx_q < 5'(PRE_LEN))
    else $error("preamble index out of range");
`endif

endmodule

`default_nettype wire

/* sv/spmi_ext_long_master.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tick-driven bus master for extended register read long / write long.
// Each input transaction on the s_axis channel is one time tick: it carries a
// start request with its command fields and the sampled level of the data pin.
// Each accepted tick yields exactly one result transaction on m_axis with the
// clock and data pin levels and enables, busy, a one-tick done with status,
// and the bytes read so far.
// The clock phase length in ticks is set through cfg_we_i / cfg_wdata_i and
// should only be written while idle; 0 is taken as 1.
// An accepted tick goes through the input register and one pass of sequencer
// logic into the result register, which drives m_axis.
// Throughput: one tick per clock cycle while m_axis is not stalled; the
// sequencer state advances once per accepted tick.
// Reset: idle, both pins released, read data zero, phase length 10 ticks.
// A stalled m_axis holds its result; the input register fills and tready
// drops, so no tick is lost or repeated.

module spmi_ext_long_master (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [sxlm_pkg::HP_W-1:0]          cfg_wdata_i,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: start_req, slave_id[3:0], reg_addr[15:0],
  // byte_count[3:0], write_data[63:0], data_in, zero fill
  input  wire [sxlm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: opcode
  input  wire                               s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata from bit 0: clock_out, clock_drive, data_out, data_drive,
  // busy_res, done_res, status[1:0], read_data[63:0]
  output logic [sxlm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import sxlm_pkg::*;

  logic     adv;
  logic     in_vld;
  logic     step;
  in_item_t item;
  res_t     res;

  logic                   m_vld_q, m_vld_d;
  logic [OUT_TDATA_W-1:0] m_data_q;

  assign adv  = !m_vld_q || m_axis_tready;
  assign step = in_vld && adv;

  sxlm_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .adv_i         (adv),
    .vld_o         (in_vld),
    .item_o        (item)
  );

  sxlm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item),
    .res_o       (res)
  );

  always_comb begin
    m_vld_d = m_vld_q;
    if (step) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      m_data_q <= {res.read_data, res.status, res.done_res, res.busy_res,
                   res.data_drive, res.data_out, res.clock_drive, res.clock_out};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sxlm_pkg::*;

  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned RAND_BUSY_TICKS = 150;
  localparam int          PART_TICKS      = 45;
  localparam int          RUN_TO_IDLE     = 32'h7fff_ffff;
  localparam longint unsigned CYCLE_LIMIT = 50_000;

  // Arbitration preamble and start condition, {data enable, data, clock}
  localparam logic [2:0] PRE_LEVELS [27] = '{
    3'd4, 3'd4,
    3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
    3'd7, 3'd6,
    3'd5, 3'd4,
    3'd7, 3'd6,
    3'd1, 3'd0,
    3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0,
    3'd7, 3'd6,
    3'd6, 3'd4
  };

  typedef struct packed {
    state_e      phase;
    logic [4:0]  pre_idx;
    logic [9:0]  ticks;
    logic [12:0] shift;
    logic [3:0]  bits_left;
    logic [3:0]  byte_idx;
    logic [63:0] rd_acc;
    status_e     stat;
    logic        op;
    logic [3:0]  sid;
    logic [15:0] addr;
    logic [3:0]  cnt;
    logic [63:0] wdata;
  } bus_state_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [HP_W-1:0]        cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  wire [IN_TDATA_W-1:0]   s_axis_tdata;
  wire                    s_axis_tuser;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;

  in_item_t               drv_item = '0;
  in_item_t               tick_q[$];
  res_t                   pin_results_q[$];

  // Generator copy runs ahead to place slave responses; checker copy follows
  // the accepted ticks
  bus_state_t             plan_bus;
  bus_state_t             pred_bus;
  logic [HP_W-1:0]        plan_hp;
  logic [HP_W-1:0]        pred_hp;
  logic [63:0]            rx_plan;
  logic [7:0]             bad_plan;
  logic                   ack_plan;

  int                     snd_pct = 0;
  int                     rcv_pct = 0;
  logic                   hold_req = 1'b0;
  logic                   hold_armed = 1'b0;
  int unsigned            hold_left = 0;
  int                     errors = 0;
  int                     busy_ticks = 0;
  longint unsigned        cycles = 0;

  // tdata from bit 0: start_req, slave_id, reg_addr, byte_count, write_data,
  // data_in, zero fill
  assign s_axis_tdata = {6'd0, drv_item.data_in, drv_item.write_data,
                         drv_item.byte_count, drv_item.reg_addr,
                         drv_item.slave_id, drv_item.start_req};
  assign s_axis_tuser = drv_item.opcode;

  spmi_ext_long_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  task automatic load_frame(inout bus_state_t s, input logic [3:0] f);
    logic [11:0] cmd;
    logic [7:0]  b;
    if (f == 4'd0) begin
      cmd = {s.sid, (s.op ? CMD_READ : CMD_WRITE) | {4'd0, s.cnt - 4'd1}};
      s.shift = {cmd, ~^cmd};
      s.bits_left = CMD_BL_LOAD;
    end else begin
      if (f == 4'd1) b = s.addr[15:8];
      else if (f == 4'd2) b = s.addr[7:0];
      else b = s.wdata[8 * ((f - HDR_FRAMES) & 4'd7) +: 8];
      s.shift = {4'd0, b, ~^b};
      s.bits_left = BYTE_BL_LOAD;
    end
  endtask

  // One tick of the pin sequencer: latch a start, emit pin levels, sample the
  // data pin and step the phase
  task automatic bus_tick(inout bus_state_t s, input logic [HP_W-1:0] hp_cfg,
                          input in_item_t t, output res_t r);
    logic [2:0]      lv;
    logic            tx_bit;
    logic [HP_W-1:0] hp;
    logic [3:0]      frames;
    logic [7:0]      rx_byte;
    r = '0;
    lv = 3'd0;
    hp = (hp_cfg == '0) ? 10'd1 : hp_cfg;
    if (s.phase == ST_IDLE && t.start_req && t.byte_count != 4'd0 &&
        t.byte_count <= MAX_BYTES) begin
      s.op = t.opcode;
      s.sid = t.slave_id;
      s.addr = t.reg_addr;
      s.cnt = t.byte_count;
      s.wdata = t.write_data;
      s.rd_acc = '0;
      s.stat = STAT_OK;
      s.ticks = '0;
      s.pre_idx = '0;
      s.phase = ST_PRE;
    end
    if (s.phase == ST_DONE) begin
      r.done_res = 1'b1;
      r.status = s.stat;
      s.phase = ST_IDLE;
    end else if (s.phase != ST_IDLE) begin
      r.busy_res = 1'b1;
      r.clock_drive = 1'b1;
      case (s.phase)
        ST_PRE: lv = PRE_LEVELS[s.pre_idx];
        ST_TX_HI, ST_TX_LO: begin
          tx_bit = (s.bits_left >= 4'd1 && s.bits_left <= 4'd13) ?
                   s.shift[s.bits_left - 4'd1] : 1'b0;
          lv = {1'b1, tx_bit, s.phase == ST_TX_HI};
        end
        ST_PARK_HI: lv = 3'd5;
        ST_ACK_HI, ST_END_HI, ST_RX_HI: lv = 3'd1;
        default: lv = 3'd0;
      endcase
      r.clock_out = lv[0];
      r.data_out = lv[1];
      r.data_drive = lv[2];
      // sample only on the first tick of the phase
      if (s.ticks == '0) begin
        if (s.phase == ST_RX_HI) s.shift = {4'd0, s.shift[7:0], t.data_in};
        else if (s.phase == ST_ACK_LO) s.stat = t.data_in ? STAT_OK : STAT_NACK;
      end
      s.ticks = s.ticks + 10'd1;
      if (s.ticks >= hp) begin
        s.ticks = '0;
        case (s.phase)
          ST_PRE: begin
            if (s.pre_idx == PRE_LEN - 1) begin
              s.byte_idx = '0;
              load_frame(s, 4'd0);
              s.phase = ST_TX_HI;
            end else begin
              s.pre_idx = s.pre_idx + 5'd1;
            end
          end
          ST_TX_HI: s.phase = ST_TX_LO;
          ST_TX_LO: begin
            if (s.bits_left != 0) s.bits_left = s.bits_left - 4'd1;
            if (s.bits_left != 0) begin
              s.phase = ST_TX_HI;
            end else begin
              s.byte_idx = s.byte_idx + 4'd1;
              frames = HDR_FRAMES + (s.op ? 4'd0 : s.cnt);
              if (s.byte_idx < frames) begin
                load_frame(s, s.byte_idx);
                s.phase = ST_TX_HI;
              end else begin
                s.phase = ST_PARK_HI;
              end
            end
          end
          ST_PARK_HI: s.phase = ST_PARK_LO;
          ST_PARK_LO: begin
            if (s.op) begin
              s.byte_idx = '0;
              s.bits_left = RX_BITS;
              s.shift = '0;
              s.phase = ST_RX_HI;
            end else begin
              s.phase = ST_ACK_HI;
            end
          end
          ST_ACK_HI: s.phase = ST_ACK_LO;
          ST_ACK_LO: s.phase = ST_END_HI;
          ST_END_HI: s.phase = ST_END_LO;
          ST_END_LO: s.phase = ST_DONE;
          ST_RX_HI: s.phase = ST_RX_LO;
          ST_RX_LO: begin
            if (s.bits_left != 0) s.bits_left = s.bits_left - 4'd1;
            if (s.bits_left != 0) begin
              s.phase = ST_RX_HI;
            end else begin
              rx_byte = s.shift[8:1];
              s.rd_acc = s.rd_acc | (64'(rx_byte) << (8 * s.byte_idx[2:0]));
              if (s.shift[0] != ~^rx_byte) begin
                s.stat = STAT_PARITY;
                s.phase = ST_END_HI;
              end else begin
                s.byte_idx = s.byte_idx + 4'd1;
                if (s.byte_idx < s.cnt) begin
                  s.bits_left = RX_BITS;
                  s.shift = '0;
                  s.phase = ST_RX_HI;
                end else begin
                  s.phase = ST_END_HI;
                end
              end
            end
          end
          default: s.phase = ST_IDLE;
        endcase
      end
    end
    r.read_data = s.rd_acc;
  endtask

  function automatic in_item_t rand_item();
    in_item_t t;
    t.start_req = 1'b0;
    t.opcode = 1'($urandom_range(0, 1));
    t.slave_id = 4'($urandom);
    t.reg_addr = 16'($urandom);
    t.byte_count = 4'($urandom);
    t.write_data = {$urandom, $urandom};
    t.data_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Queue one tick, answering as the slave where the master samples the pin
  task automatic queue_tick(input in_item_t t);
    res_t       r;
    logic [7:0] rx_byte;
    logic [8:0] frame;
    rx_byte = rx_plan[8 * plan_bus.byte_idx[2:0] +: 8];
    frame = {rx_byte, ~^rx_byte ^ bad_plan[plan_bus.byte_idx[2:0]]};
    if (plan_bus.phase == ST_RX_HI && plan_bus.ticks == '0)
      t.data_in = frame[plan_bus.bits_left - 4'd1];
    else if (plan_bus.phase == ST_ACK_LO && plan_bus.ticks == '0)
      t.data_in = ack_plan;
    bus_tick(plan_bus, plan_hp, t, r);
    if (r.busy_res) busy_ticks++;
    tick_q.push_back(t);
  endtask

  task automatic queue_start(input logic op, input logic [3:0] sid,
                             input logic [15:0] addr, input logic [3:0] cnt,
                             input logic [63:0] wdata, input logic [63:0] rx_bytes,
                             input logic [7:0] bad, input logic ack);
    in_item_t t;
    rx_plan = rx_bytes;
    bad_plan = bad;
    ack_plan = ack;
    t = rand_item();
    t.start_req = 1'b1;
    t.opcode = op;
    t.slave_id = sid;
    t.reg_addr = addr;
    t.byte_count = cnt;
    t.write_data = wdata;
    queue_tick(t);
  endtask

  task automatic queue_rest(input int limit);
    in_item_t t;
    int n;
    n = 0;
    // stray starts while busy and on the done tick must be dropped
    while (plan_bus.phase != ST_IDLE && n < limit) begin
      t = rand_item();
      if (plan_bus.phase == ST_DONE) t.start_req = 1'($urandom_range(0, 1));
      else t.start_req = ($urandom_range(0, 99) < 3);
      queue_tick(t);
      n++;
    end
  endtask

  task automatic queue_transfer(input logic op, input logic [3:0] sid,
                                input logic [15:0] addr, input logic [3:0] cnt,
                                input logic [63:0] wdata, input logic [63:0] rx_bytes,
                                input logic [7:0] bad, input logic ack);
    queue_start(op, sid, addr, cnt, wdata, rx_bytes, bad, ack);
    queue_rest(RUN_TO_IDLE);
  endtask

  task automatic queue_random(input int busy_target);
    in_item_t t;
    logic [7:0] bad;
    int first;
    int i;
    first = busy_ticks;
    while (busy_ticks - first < busy_target) begin
      if ($urandom_range(0, 9) == 0) begin
        t = rand_item();
        t.start_req = 1'b1;
        t.byte_count = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
        queue_tick(t);
      end
      for (i = 0; i < 8; i++) bad[i] = ($urandom_range(0, 99) < 5);
      queue_transfer(1'($urandom_range(0, 1)), 4'($urandom), 16'($urandom),
                     4'($urandom_range(1, 8)), {$urandom, $urandom},
                     {$urandom, $urandom}, bad, ($urandom_range(0, 99) < 85));
      repeat ($urandom_range(0, 3)) queue_tick(rand_item());
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || pin_results_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic start_phase(input logic [HP_W-1:0] hp, input int snd, input int rcv);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hp;
    snd_pct <= snd;
    rcv_pct <= rcv;
    plan_hp = hp;
    pred_hp = hp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    res_t pred;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      drv_item <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bus_tick(pred_bus, pred_hp, drv_item, pred);
        pin_results_q.push_back(pred);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= snd_pct) begin
          drv_item <= tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_armed <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_pct);
  end

  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3],
             m_axis_tdata[4], m_axis_tdata[5], m_axis_tdata[7:6], m_axis_tdata[71:8]};
      if (pin_results_q.size() == 0) begin
        $display("%0t: result with no tick pending, expected none, actual %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = pin_results_q.pop_front();
        check_field("clock_out", 64'(want.clock_out), 64'(got.clock_out));
        check_field("clock_drive", 64'(want.clock_drive), 64'(got.clock_drive));
        check_field("data_out", 64'(want.data_out), 64'(got.data_out));
        check_field("data_drive", 64'(want.data_drive), 64'(got.data_drive));
        check_field("busy", 64'(want.busy_res), 64'(got.busy_res));
        check_field("done", 64'(want.done_res), 64'(got.done_res));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("read_data", want.read_data, got.read_data);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[spmi_ext_long_master] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t t;
    plan_bus = '0;
    plan_bus.phase = ST_IDLE;
    pred_bus = plan_bus;
    plan_hp = HP_RESET;
    pred_hp = HP_RESET;
    rx_plan = '0;
    bad_plan = '0;
    ack_plan = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset phase length: run the first preamble phases of a long write
    queue_start(1'b0, 4'hf, 16'hffff, 4'd8, '1, 64'h0, 8'h00, 1'b0);
    queue_rest(PART_TICKS);

    // finish it at one tick per phase, then drop bad starts
    start_phase(10'd1, 0, 0);
    queue_rest(RUN_TO_IDLE);
    t = rand_item();
    t.start_req = 1'b1;
    t.byte_count = 4'd0;
    queue_tick(t);
    t.byte_count = 4'd9;
    queue_tick(t);
    t.byte_count = 4'd15;
    queue_tick(t);
    // hold the result side off mid-run so the input side backs up
    repeat (40) @(posedge clk_i);
    hold_req <= 1'b1;

    start_phase(10'd0, 61, 0);
    queue_transfer(1'b1, 4'h5, 16'h8001, 4'd3, 64'h0, 64'hff00_5aa5_0180_fe7f, 8'h00,
                   1'b1);
    queue_transfer(1'b1, 4'ha, 16'h1234, 4'd8, 64'h0, 64'h1122_3344_5566_7788, 8'h08,
                   1'b1);

    // longest phase: count part of one phase, then shorten it
    start_phase(10'd1023, 0, 61);
    queue_start(1'b0, 4'h6, 16'h5aa5, 4'd1, 64'h0123_4567_89ab_cdef, 64'h0, 8'h00,
                1'b1);
    queue_rest(20);
    start_phase(10'd1, 0, 61);
    queue_rest(RUN_TO_IDLE);
    queue_random(RAND_BUSY_TICKS);

    start_phase(10'd2, 35, 35);
    queue_random(RAND_BUSY_TICKS);

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[spmi_ext_long_master] OK");
    end else begin
      $display("[spmi_ext_long_master] ERROR");
    end
    $finish;
  end

endmodule
